// ===== rtl/ohlcv_bar_aggregator_top_assert.svh =====
// assertion helpers, clocked on clk and disabled in reset
`ifndef OHLCV_BAR_AGGREGATOR_TOP_ASSERT_SVH
`define OHLCV_BAR_AGGREGATOR_TOP_ASSERT_SVH

`define OLBA_AST_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("bar aggregator check failed");

`define OLBA_AST_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("bar aggregator check failed");

`endif

// ===== rtl/olba_pkg.sv =====
package olba_pkg;

  localparam int NUM_SLOTS_DEF = 4;
  localparam int NUM_REGS      = 4;
  localparam int LEN_W         = 16;
  localparam int STEP_W        = 31;
  localparam int FINAL_W       = 32;
  localparam int PX_W          = 32;
  localparam int QTY_W         = 32;
  localparam int SUM_W         = 64;
  localparam int CNT_W         = 32;
  localparam int CFG_IDX_W     = 8;

  typedef struct packed {
    logic [STEP_W-1:0] base;
    logic [PX_W-1:0]   px;
    logic [QTY_W-1:0]  qty;
    logic [SUM_W-1:0]  prod;
  } link_t;

  typedef struct packed {
    logic [STEP_W-1:0] bar_start;
    logic [PX_W-1:0]   open_px;
    logic [PX_W-1:0]   high_px;
    logic [PX_W-1:0]   low_px;
    logic [PX_W-1:0]   close_px;
    logic [SUM_W-1:0]  qty_sum;
    logic [SUM_W-1:0]  notional_sum;
    logic [CNT_W-1:0]  trades;
  } bar_t;

  typedef struct packed {
    logic              req;
    logic [STEP_W-1:0] base;
    logic [LEN_W-1:0]  len;
  } div_req_t;

  function automatic logic [LEN_W-1:0] len_reset_val(input int idx);
    logic [LEN_W-1:0] v;
    v = (idx == 0) ? LEN_W'(1) : '0;
    return v;
  endfunction

endpackage

// ===== rtl/ohlcv_bar_aggregator_top.sv =====
// Flow: a trade is registered, its notional formed in S_MUL, then it passes the cells
//   in order; a rolled-over bar waits on the shared one-bit-per-cycle divider.
// Throughput: one trade at a time; the next is taken only once the chain, the emit
//   pass of a last-of-step trade and any output stall are done.
// Reset: rst is synchronous; clears all bars, bar_len_0 returns to 1, others to 0.
`include "ohlcv_bar_aggregator_top_assert.svh"
module ohlcv_bar_aggregator_top #(
  parameter int NUM_SLOTS = olba_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           trade_valid,
  output logic                           trade_ready,
  input  logic [olba_pkg::STEP_W-1:0]    step_number,
  input  logic [olba_pkg::PX_W-1:0]      trade_price,
  input  logic [olba_pkg::QTY_W-1:0]     trade_qty,
  input  logic                           last_of_step,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [olba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [olba_pkg::LEN_W-1:0]     cfg_data,
  output logic                           bar_valid,
  input  logic                           bar_ready,
  output logic [olba_pkg::LEN_W-1:0]     bar_length,
  output logic [olba_pkg::STEP_W-1:0]    first_step,
  output logic [olba_pkg::FINAL_W-1:0]   final_step,
  output logic [olba_pkg::PX_W-1:0]      open_px,
  output logic [olba_pkg::PX_W-1:0]      high_px,
  output logic [olba_pkg::PX_W-1:0]      low_px,
  output logic [olba_pkg::PX_W-1:0]      close_px,
  output logic [olba_pkg::SUM_W-1:0]     total_qty,
  output logic [olba_pkg::SUM_W-1:0]     total_notional,
  output logic [olba_pkg::CNT_W-1:0]     trades_in_bar,
  output logic                           last_bar
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SW = olba_pkg::STEP_W;
  localparam int LW = olba_pkg::LEN_W;
  localparam int IW = olba_pkg::CFG_IDX_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MUL   = 4'b0010,
    S_CHAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                state;
  olba_pkg::link_t       link0;
  olba_pkg::link_t       inj;
  logic                  last_flag;
  logic [SLOT_W-1:0]     eidx;
  logic [LW-1:0]         lens [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  en;
  logic [NUM_SLOTS-1:0]  clr;
  logic [NUM_SLOTS-1:0]  tok_vec;
  logic [NUM_SLOTS:0]    hand;
  olba_pkg::link_t       links [NUM_SLOTS+1];
  olba_pkg::div_req_t    reqs [NUM_SLOTS];
  olba_pkg::bar_t        bars [NUM_SLOTS];
  olba_pkg::div_req_t    div_req;
  logic                  div_done;
  logic [SW-1:0]         div_open;
  logic                  cfg_hit;
  logic                  any_later;
  logic                  out_free;
  logic                  emit_go;
  olba_pkg::bar_t        sel;

  assign trade_ready = (state == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign cfg_hit     = cfg_valid && (cfg_index < IW'(olba_pkg::NUM_REGS))
                       && (cfg_index < IW'(NUM_SLOTS));

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      en[s]  = (lens[s] != '0);
      clr[s] = cfg_hit && (cfg_index[SLOT_W-1:0] == SLOT_W'(s));
      for (int e = 0; e < s; e++) begin
        if (lens[e] == lens[s]) en[s] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) lens[s] <= olba_pkg::len_reset_val(s);
    end else if (cfg_hit) begin
      lens[cfg_index[SLOT_W-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    inj      = link0;
    inj.prod = link0.px * link0.qty;
  end

  assign hand[0]  = (state == S_MUL);
  assign links[0] = inj;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    olba_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .hand_in  (hand[g]),
      .link_in  (links[g]),
      .len      (lens[g]),
      .en       (en[g]),
      .clr      (clr[g]),
      .div_done (div_done),
      .div_open (div_open),
      .hand_out (hand[g+1]),
      .link_out (links[g+1]),
      .req      (reqs[g]),
      .bar      (bars[g]),
      .tok      (tok_vec[g])
    );
  end

  always_comb begin
    div_req = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (reqs[s].req) div_req = reqs[s];
    end
  end

  olba_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_req.req),
    .dividend  (div_req.base),
    .divisor   (div_req.len),
    .done      (div_done),
    .aligned   (div_open)
  );

  always_comb begin
    any_later = 1'b0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (SLOT_W'(s) > eidx && en[s]) any_later = 1'b1;
    end
  end

  assign sel      = bars[eidx];
  assign out_free = !bar_valid || bar_ready;
  assign emit_go  = (state == S_EMIT) && en[eidx] && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bar_valid <= 1'b0;
    end else begin
      if (emit_go) bar_valid <= 1'b1;
      else if (bar_valid && bar_ready) bar_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (trade_valid) begin
            link0.base <= (step_number == '0) ? '0 : step_number - SW'(1);
            link0.px   <= trade_price;
            link0.qty  <= trade_qty;
            link0.prod <= '0;
            last_flag  <= last_of_step;
            state      <= S_MUL;
          end
        end
        S_MUL: state <= S_CHAIN;
        S_CHAIN: begin
          if (hand[NUM_SLOTS]) begin
            eidx  <= '0;
            state <= last_flag ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (!en[eidx] || out_free) begin
            if (en[eidx]) begin
              bar_length     <= lens[eidx];
              first_step     <= sel.bar_start;
              final_step     <= {1'b0, sel.bar_start} + olba_pkg::FINAL_W'(lens[eidx])
                                - olba_pkg::FINAL_W'(1);
              open_px        <= sel.open_px;
              high_px        <= sel.high_px;
              low_px         <= sel.low_px;
              close_px       <= sel.close_px;
              total_qty      <= sel.qty_sum;
              total_notional <= sel.notional_sum;
              trades_in_bar  <= sel.trades;
              last_bar       <= !any_later;
            end
            if (eidx == SLOT_W'(NUM_SLOTS - 1)) state <= S_IDLE;
            else eidx <= eidx + SLOT_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OLBA_AST_IMP(a_tok_single, 1'b1, $onehot0(tok_vec))
  `OLBA_AST_IMP(a_idle_empty, trade_ready, tok_vec == '0)
  `OLBA_AST_IMP(a_div_owner, div_done, div_req.req)
  `OLBA_AST_NXT(a_emit_start, (state == S_CHAIN) && hand[NUM_SLOTS] && last_flag, state == S_EMIT)

endmodule

// ===== rtl/olba_div.sv =====
module olba_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [olba_pkg::STEP_W-1:0]   dividend,
  input  logic [olba_pkg::LEN_W-1:0]    divisor,
  output logic                          done,
  output logic [olba_pkg::STEP_W-1:0]   aligned
);

  localparam int SW = olba_pkg::STEP_W;
  localparam int LW = olba_pkg::LEN_W;
  localparam int CW = $clog2(SW);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_RUN  = 4'b0010,
    D_MUL  = 4'b0100,
    D_DONE = 4'b1000
  } dstate_t;

  dstate_t        state;
  logic [SW-1:0]  dvd;
  logic [LW-1:0]  dvs;
  logic [LW-1:0]  rem;
  logic [CW-1:0]  cnt;
  logic [SW-1:0]  prod;
  logic [LW:0]    rem_sh;
  logic           ge;

  assign rem_sh = {rem, dvd[SW-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign done    = (state == D_DONE);
  assign aligned = prod + SW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (start) begin
            dvd   <= dividend;
            dvs   <= divisor;
            rem   <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= ge ? LW'(rem_sh - {1'b0, dvs}) : rem_sh[LW-1:0];
          dvd <= {dvd[SW-2:0], ge};
          cnt <= cnt + CW'(1);
          if (cnt == CW'(SW - 1)) state <= D_MUL;
        end
        D_MUL: begin
          // quotient * divisor never exceeds the dividend
          prod  <= SW'(dvd * dvs);
          state <= D_DONE;
        end
        D_DONE: begin
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/olba_cell.sv =====
module olba_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        hand_in,
  input  olba_pkg::link_t             link_in,
  input  logic [olba_pkg::LEN_W-1:0]  len,
  input  logic                        en,
  input  logic                        clr,
  input  logic                        div_done,
  input  logic [olba_pkg::STEP_W-1:0] div_open,
  output logic                        hand_out,
  output olba_pkg::link_t             link_out,
  output olba_pkg::div_req_t          req,
  output olba_pkg::bar_t              bar,
  output logic                        tok
);

  localparam int SW = olba_pkg::STEP_W;

  olba_pkg::link_t link;
  olba_pkg::bar_t  st;
  logic            live;
  logic [SW-1:0]   open_m1;
  logic [SW-1:0]   diff;
  logic            in_bar;
  logic            need_div;
  logic            go;

  assign open_m1  = st.bar_start - SW'(1);
  assign diff     = link.base - open_m1;
  assign in_bar   = live && (link.base >= open_m1) && (diff < SW'(len));
  assign need_div = en && !in_bar;
  assign go       = tok && (!need_div || div_done);

  assign hand_out = go;
  assign link_out = link;
  assign bar      = st;
  assign req.req  = tok && need_div;
  assign req.base = link.base;
  assign req.len  = len;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok  <= 1'b0;
      live <= 1'b0;
    end else begin
      if (hand_in) begin
        tok  <= 1'b1;
        link <= link_in;
      end else if (go) begin
        tok <= 1'b0;
      end
      if (clr) begin
        live <= 1'b0;
      end else if (go) begin
        if (!en) begin
          live <= 1'b0;
        end else begin
          live <= 1'b1;
          st.close_px <= link.px;
          if (!in_bar) begin
            st.bar_start    <= div_open;
            st.open_px      <= link.px;
            st.high_px      <= link.px;
            st.low_px       <= link.px;
            st.qty_sum      <= olba_pkg::SUM_W'(link.qty);
            st.notional_sum <= link.prod;
            st.trades       <= olba_pkg::CNT_W'(1);
          end else begin
            if (link.px > st.high_px) st.high_px <= link.px;
            if (link.px < st.low_px) st.low_px <= link.px;
            st.qty_sum      <= st.qty_sum + olba_pkg::SUM_W'(link.qty);
            st.notional_sum <= st.notional_sum + link.prod;
            if (st.trades != '1) st.trades <= st.trades + olba_pkg::CNT_W'(1);
          end
        end
      end
    end
  end

endmodule
